### rtl/serial_security_pic_top_macros.svh
// assertion helpers used by the rtl top
`ifndef SERIAL_SECURITY_PIC_TOP_MACROS_SVH
`define SERIAL_SECURITY_PIC_TOP_MACROS_SVH

// same-cycle implication
`define SSPIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspic assertion failed");

// next-cycle implication
`define SSPIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspic assertion failed");

`endif

### rtl/sspic_pkg.sv
package sspic_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int POS_W       = $clog2(TABLE_DEPTH);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   // access kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAME_NUMBER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_HIGH = 2'd2;

   localparam logic [9:0] GAME_NO_MASK = 10'd419;
   localparam logic [7:0] OR_MASK      = 8'h80;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status_bit;
   } rsp_type;

   // decimal digits of the game number plus the random bytes
   typedef struct packed {
      logic [3:0] digit_hund;
      logic [3:0] digit_tens;
      logic [3:0] digit_ones;
      logic [7:0] random_low;
      logic [7:0] random_high;
   } sspic_cfg_type;

endpackage

### rtl/sspic_table.sv
module sspic_table (
   input  sspic_pkg::sspic_cfg_type       cfg,
   input  logic [sspic_pkg::POS_W-1:0]    position,
   output logic [7:0]                     entry_byte
);
   import sspic_pkg::*;

   logic [8:0]  sum_a;
   logic [16:0] sum_b;
   logic [11:0] sum_c;
   logic [23:0] word_a;
   logic [31:0] word_b;
   logic [23:0] word_c;

   // fixed low serial digits 1,2,3,4,5,6 folded into the offsets
   assign sum_a = 9'd130 + 9'(cfg.random_low);
   assign sum_b = 17'd64 + 17'(cfg.digit_hund) * 17'd100
                + 17'(cfg.digit_ones) * 17'd10000
                + {8'd0, cfg.random_high, 1'b0} + 17'(cfg.random_low);
   assign sum_c = 12'd52 + 12'(cfg.digit_tens) * 12'd100
                + 12'(cfg.random_high) * 12'd5;

   assign word_a = 24'(sum_a) * 24'h000245 + 24'h003d74;
   assign word_b = 32'(sum_b) * 32'h0000107f + 32'h0071e259;
   assign word_c = 24'(sum_c) * 24'h001bcd + 24'h01f3f0;

   always_comb begin
      unique case (position)
         4'd0:    entry_byte = word_a[7:0];
         4'd1:    entry_byte = word_a[15:8];
         4'd2:    entry_byte = word_a[23:16];
         4'd3:    entry_byte = word_b[7:0];
         4'd4:    entry_byte = word_b[15:8];
         4'd5:    entry_byte = word_b[23:16];
         4'd6:    entry_byte = word_b[31:24];
         4'd7:    entry_byte = word_c[7:0];
         4'd8:    entry_byte = word_c[15:8];
         4'd9:    entry_byte = word_c[23:16];
         // date code 1994-12-11 scrambled to 0x15b8
         4'd10:   entry_byte = 8'h15;
         4'd11:   entry_byte = 8'hb8;
         4'd12:   entry_byte = cfg.random_low;
         4'd13:   entry_byte = cfg.random_high;
         default: entry_byte = 8'h00;
      endcase
   end

endmodule

### rtl/serial_security_pic_top.sv
// a request is accepted into the input register and passes to the response register once that is free
// throughput: one transaction per cycle while rsp_stall is low, set by the single input and response registers
// the serial table is decoded from the config registers, no table storage
// reset is synchronous: clears valid flags, status, position, latched byte and config registers
`include "serial_security_pic_top_macros.svh"

module serial_security_pic_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sspic_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sspic_pkg::rsp_type                 rsp_data,
   input  logic                               csr_we,
   input  logic [sspic_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sspic_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sspic_pkg::*;

   // config
   sspic_cfg_type cfg_ff, cfg_in;
   logic          no_mask_ff, no_mask_in;

   // digit split of the written game number
   logic [17:0] prod_tens;
   logic [15:0] prod_hund;
   logic [6:0]  quot_tens;
   logic [3:0]  quot_hund;
   logic [9:0]  ones_rem;
   logic [6:0]  tens_rem;

   // pipeline
   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff, in_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          out_free;
   logic          advance;
   logic          req_take;

   // block state
   logic [7:0]       latched_ff, latched_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic             status_ff, status_in;
   logic             take_table;
   logic [7:0]       table_byte;

   sspic_table u_table (
      .cfg        (cfg_ff),
      .position   (position_ff),
      .entry_byte (table_byte)
   );

   // floor(g/10) = g*205>>11 and floor(g/100) = g*41>>12 hold for every 10-bit g
   assign prod_tens = 18'(csr_wdata) * 18'd205;
   assign prod_hund = 16'(csr_wdata) * 16'd41;
   assign quot_tens = prod_tens[17:11];
   assign quot_hund = prod_hund[15:12];
   assign ones_rem  = csr_wdata - ({3'd0, quot_tens} << 3) - ({3'd0, quot_tens} << 1);
   assign tens_rem  = quot_tens - ({3'd0, quot_hund} << 3) - ({3'd0, quot_hund} << 1);

   always_comb begin
      cfg_in     = cfg_ff;
      no_mask_in = no_mask_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAME_NUMBER: begin
               cfg_in.digit_ones = ones_rem[3:0];
               cfg_in.digit_tens = tens_rem[3:0];
               cfg_in.digit_hund = (quot_hund >= 4'd10) ? quot_hund - 4'd10 : quot_hund;
               no_mask_in        = (csr_wdata == GAME_NO_MASK);
            end
            CSR_RANDOM_LOW:  cfg_in.random_low  = csr_wdata[7:0];
            CSR_RANDOM_HIGH: cfg_in.random_high = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign in_data_in   = req_take ? req_data : in_data_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      latched_in  = latched_ff;
      position_in = position_ff;
      status_in   = status_ff;
      take_table  = 1'b0;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in.read_data = 8'h00;
         unique case (in_data_ff.kind)
            KIND_WRITE: begin
               status_in = in_data_ff.write_data[4];
               if (!in_data_ff.write_data[4]) begin
                  if (in_data_ff.write_data[3:0] != 4'd0) begin
                     latched_in = in_data_ff.write_data | (no_mask_ff ? 8'h00 : OR_MASK);
                  end else begin
                     take_table  = 1'b1;
                     latched_in  = table_byte;
                     position_in = position_ff + POS_W'(1);
                  end
               end
            end
            KIND_READ: begin
               status_in             = 1'b1;
               rsp_data_in.read_data = latched_ff;
            end
            // status access and the unused code leave state alone
            default: ;
         endcase
         rsp_data_in.status_bit = status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         no_mask_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         latched_ff   <= 8'h00;
         position_ff  <= '0;
         status_ff    <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         no_mask_ff   <= no_mask_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         latched_ff   <= latched_in;
         position_ff  <= position_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSPIC_ASSERT_NEXT(a_read_sets_status, clock, reset, advance && in_data_ff.kind == KIND_READ, rsp_valid && rsp_data.status_bit)
   `SSPIC_ASSERT_NEXT(a_nonread_zero_data, clock, reset, advance && in_data_ff.kind != KIND_READ, rsp_valid && rsp_data.read_data == 8'h00)
   `SSPIC_ASSERT_NEXT(a_position_holds, clock, reset, !take_table, position_ff == $past(position_ff))
   `SSPIC_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sspic_pkg::*;

   class sspic_scoreboard;
      logic [9:0] game_no = '0;
      logic [7:0] rand_lo = '0;
      logic [7:0] rand_hi = '0;
      logic [7:0] latch   = '0;
      logic [3:0] pos     = '0;
      logic       status  = 1'b0;

      rsp_type pending [$];
      int errors;
      int reads;
      int table_latches;
      int literal_latches;
      int held_writes;

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_GAME_NUMBER: game_no = val;
            CSR_RANDOM_LOW:  rand_lo = val[7:0];
            CSR_RANDOM_HIGH: rand_hi = val[7:0];
            default: ;
         endcase
      endfunction

      // serial table entry, decoded from the current settings
      function logic [7:0] serial_byte(logic [3:0] p);
         bit [31:0] serial;
         bit [31:0] divisor;
         bit [31:0] t;
         bit [31:0] dig [9];
         serial  = 32'd123456 + {22'd0, game_no} * 32'd1000000;
         divisor = 32'd100000000;
         for (int i = 0; i < 9; i++) begin
            dig[i]  = (serial / divisor) % 10;
            divisor = divisor / 10;
         end
         case (p)
            4'd0, 4'd1, 4'd2: begin
               t = (dig[5] * 10 + dig[3] * 100 + rand_lo) * 32'h245 + 32'h3d74;
               t = t >> (8 * p);
            end
            4'd3, 4'd4, 4'd5, 4'd6: begin
               t = dig[6] + dig[8] * 10 + dig[0] * 100 + dig[2] * 10000;
               t = (t + 2 * rand_hi + rand_lo) * 32'h107f + 32'h71e259;
               t = t >> (8 * (p - 3));
            end
            4'd7, 4'd8, 4'd9: begin
               t = dig[4] + dig[7] * 10 + dig[1] * 100;
               t = (t + 5 * rand_hi) * 32'h1bcd + 32'h1f3f0;
               t = t >> (8 * (p - 7));
            end
            4'd10, 4'd11: begin
               // date code: year 1994, month 12, day 11
               t = 32'h174 * (1994 - 1980) + 32'h1f * (12 - 1) + 11;
               if (p == 4'd10) t = t >> 8;
            end
            4'd12:   t = rand_lo;
            4'd13:   t = rand_hi;
            default: t = 0;
         endcase
         return t[7:0];
      endfunction

      function void note_request(req_type r);
         rsp_type exp;
         exp.read_data = '0;
         case (r.kind)
            KIND_WRITE: begin
               status = r.write_data[4];
               if (status) begin
                  held_writes++;
               end else if (r.write_data[3:0] != 4'h0) begin
                  latch = r.write_data | ((game_no == GAME_NO_MASK) ? 8'h00 : OR_MASK);
                  literal_latches++;
               end else begin
                  latch = serial_byte(pos);
                  pos   = pos + 1'b1;
                  table_latches++;
               end
            end
            KIND_READ: begin
               status        = 1'b1;
               exp.read_data = latch;
               reads++;
            end
            default: ;   // status access and the unused kind change nothing
         endcase
         exp.status_bit = status;
         pending.push_back(exp);
      endfunction

      function void check_response(rsp_type r);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected transaction: read_data %02h status_bit %b",
                   r.read_data, r.status_bit);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (r.read_data !== exp.read_data) begin
            $error("read_data: expected %02h, actual %02h", exp.read_data, r.read_data);
            errors++;
         end
         if (r.status_bit !== exp.status_bit) begin
            $error("status_bit: expected %b, actual %b", exp.status_bit, r.status_bit);
            errors++;
         end
      endfunction
   endclass

   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 500;
   localparam int         NUM_SETTINGS   = 8;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sspic_scoreboard sb = new;
   bit idling_on = 1'b1;
   int items_sent;
   int send_quiet;
   int stall_left;
   int stall_quiet;
   int idle_cycles;
   int settings_used = 1;

   serial_security_pic_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // transactions are seen with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_quiet > 0) begin
            stall_quiet <= stall_quiet - 1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: stall_left  <= $urandom_range(1, 7);
               3:       stall_quiet <= $urandom_range(10, 40);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a rising edge, returns at the edge where the transaction is taken
   task automatic send_request(logic [1:0] kind, logic [7:0] data);
      int gap;
      gap = 0;
      if (send_quiet > 0) begin
         send_quiet--;
      end else if (idling_on) begin
         case ($urandom_range(0, 9))
            0, 1:    gap = $urandom_range(1, 7);
            2:       send_quiet = $urandom_range(10, 40);
            default: ;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.kind       <= kind;
      req_data.write_data <= data;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      // response pipeline is two deep
      repeat (4) @(posedge clock);
   endtask

   task automatic program_settings(logic [9:0] game, logic [7:0] lo, logic [7:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_GAME_NUMBER;
      csr_wdata <= game;
      @(posedge clock);
      sb.write_register(CSR_GAME_NUMBER, game);
      csr_index <= CSR_RANDOM_LOW;
      csr_wdata <= {2'b00, lo};
      @(posedge clock);
      sb.write_register(CSR_RANDOM_LOW, {2'b00, lo});
      csr_index <= CSR_RANDOM_HIGH;
      csr_wdata <= {2'b00, hi};
      @(posedge clock);
      sb.write_register(CSR_RANDOM_HIGH, {2'b00, hi});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      send_request(KIND_STATUS, 8'h00);
      send_request(KIND_READ,   8'hff);
      send_request(KIND_WRITE,  8'h00);   // first table entry
      send_request(KIND_READ,   8'h00);
      send_request(KIND_WRITE,  8'h0f);   // literal, or-mask applied
      send_request(KIND_READ,   8'h00);
      send_request(KIND_WRITE,  8'hff);   // status set, latch held
      send_request(KIND_READ,   8'h00);
      send_request(KIND_WRITE,  8'hef);
      send_request(KIND_READ,   8'h00);
      send_request(KIND_WRITE,  8'h10);   // status set with zero nibble, position holds
      send_request(KIND_WRITE,  8'he0);
      send_request(KIND_READ,   8'h00);
      send_request(KIND_UNUSED, 8'haa);
      send_request(KIND_STATUS, 8'h55);
      send_request(KIND_WRITE,  8'h01);
      send_request(KIND_READ,   8'h00);
      send_request(KIND_WRITE,  8'h20);
      send_request(KIND_READ,   8'h00);
   endtask

   task automatic run_random(int count);
      int stop_at;
      int len;
      logic [7:0] d;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // walk the serial table
               len = $urandom_range(1, 6);
               repeat (len) begin
                  send_request(KIND_WRITE, {3'($urandom), 1'b0, 4'h0});
                  if ($urandom_range(0, 9) < 7) send_request(KIND_READ, 8'($urandom));
               end
            end
            5, 6: begin
               d    = 8'($urandom);
               d[4] = 1'b0;
               if (d[3:0] == 4'h0) d[0] = 1'b1;
               send_request(KIND_WRITE, d);
               send_request(KIND_READ, 8'($urandom));
               if ($urandom_range(0, 1) == 1) send_request(KIND_STATUS, 8'($urandom));
            end
            7: begin
               d    = 8'($urandom);
               d[4] = 1'b1;
               send_request(KIND_WRITE, d);
               send_request(KIND_WRITE, 8'($urandom));
               send_request(KIND_READ, 8'($urandom));
            end
            default: begin
               len = $urandom_range(1, 4);
               repeat (len) send_request(2'($urandom), 8'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(200);
      drain();
      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         case (ph)
            0: program_settings(10'd1023, 8'hff, 8'hff);
            1: program_settings(GAME_NO_MASK, 8'($urandom), 8'($urandom));
            2: program_settings(10'd0, 8'h00, 8'h00);
            3: program_settings(10'd999, 8'h01, 8'hfe);
            4: program_settings(10'd1000, 8'h80, 8'h7f);
            5: program_settings(10'($urandom_range(0, 1023)), 8'($urandom), 8'($urandom));
            6: program_settings(GAME_NO_MASK, 8'h00, 8'hff);
            default: program_settings(10'($urandom_range(0, 999)), 8'($urandom),
                                      8'($urandom));
         endcase
         // last stretch runs at full rate on both sides
         if (ph == NUM_SETTINGS - 1) idling_on = 1'b0;
         run_random(195);
         drain();
      end
      if (sb.pending.size() != 0) begin
         $error("%0d expected transactions never arrived", sb.pending.size());
         sb.errors++;
      end
      $display("ran %0d transactions under %0d register settings",
               items_sent, settings_used);
      $display("%0d table latches, %0d literal latches, %0d held writes, %0d reads",
               sb.table_latches, sb.literal_latches, sb.held_writes, sb.reads);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### serial_security_pic_top.f
+incdir+rtl
rtl/sspic_pkg.sv
rtl/sspic_table.sv
rtl/serial_security_pic_top.sv
dv/testbench.sv
